@@ rtl/tld_pkg.sv @@
// Shared constants, types and calendar functions for the timestamp to local date core.
`timescale 1ns / 1ps

package tld_pkg;

   // Span of timestamps that the core converts.
   localparam logic [31:0] EPOCH_2000  = 32'd946684800;
   localparam logic [31:0] LAST_SECOND = 32'd4102444799;

   // Reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT over the value range used.
   localparam logic [25:0] RECIP_DAY       = 26'd50903317;  // (t >> 7) / 675
   localparam int          DAY_SHIFT       = 35;
   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
   localparam logic [16:0] RECIP_CYCLE     = 17'd91868;     // day number / 1461
   localparam int          CYCLE_SHIFT     = 27;
   localparam logic [10:0] DAYS_PER_CYCLE  = 11'd1461;
   localparam logic [17:0] RECIP_HOUR      = 18'd149131;    // second of day / 3600
   localparam int          HOUR_SHIFT      = 29;
   localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
   localparam logic [12:0] RECIP_MINUTE    = 13'd4370;      // second of hour / 60
   localparam int          MINUTE_SHIFT    = 18;
   localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;

   localparam logic [10:0] LEAP_YEAR_DAYS  = 11'd366;
   localparam logic [10:0] YEAR_DAYS       = 11'd365;
   localparam logic [10:0] TWO_YEAR_DAYS   = 11'd730;
   localparam logic [11:0] BASE_YEAR       = 12'd2000;

   localparam logic [3:0]  JANUARY         = 4'd1;
   localparam logic [3:0]  FEBRUARY        = 4'd2;
   localparam logic [3:0]  MARCH           = 4'd3;
   localparam logic [3:0]  DECEMBER        = 4'd12;

   localparam logic [6:0]  HOURS_PER_DAY   = 7'd24;
   localparam logic signed [4:0] ZONE_RESET = 5'sd8;
   localparam logic signed [4:0] ZONE_MIN   = -5'sd12;
   localparam logic signed [4:0] ZONE_MAX   = 5'sd12;

   // UTC date and hour as it leaves the calendar stages, with the raw zone offset.
   typedef struct packed {
      logic [6:0]        year_idx;  // years since 2000
      logic              leap;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic signed [4:0] zone;
   } utc_date_type;

   // Local date and hour after the zone shift.
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
   } local_date_type;

   function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
      logic [4:0] n;
      if (month == FEBRUARY) begin
         n = leap ? 5'd29 : 5'd28;
      end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         n = 5'd30;
      end else begin
         n = 5'd31;
      end
      return n;
   endfunction

   // Zero-based day of year on which a month begins.
   function automatic logic [8:0] month_start(logic [3:0] month, logic leap);
      logic [8:0] s;
      case (month)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && month >= MARCH) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage

@@ rtl/timestamp_to_local_date_core.sv @@
// Top level of the timestamp to local date core: seven-stage conversion pipeline.
`timescale 1ns / 1ps

// This core turns a 32-bit Unix timestamp into the local calendar date and time of day. Each
// beat on the req_ side carries one timestamp and yields exactly one beat on the rsp_ side with
// year, month, day, hour, minute and second, in order. Timestamps before 2000-01-01 00:00:00 UTC
// or after 2099-12-31 23:59:59 UTC are converted as those limits, and the leap rule is "year
// divisible by four", which is exact over that span. The date is then shifted by the zone
// offset held in the csr_ register (signed whole hours, reset value +8, values beyond +/-12 act
// as +/-12), so the reported year runs from 1999 to 2100. The csr_ port is always ready and
// should be written only while no conversion is in flight. The core is a seven-stage pipeline
// that accepts one beat every cycle while the output is not stalled; the depth is set by the
// chain of reciprocal multiplications (by day, by four-year cycle, by hour and by minute), each
// of which gets its own register stage. Stages hold while the output is stalled, and empty
// stages still take new beats, so throughput is one beat per cycle whenever rsp_tready is
// high.

module timestamp_to_local_date_core (
   input  logic        clock,
   input  logic        reset,
   // Timestamp input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] timestamp
   // Local date output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
                                    // [31:26] minute, [37:32] second, [39:38] zero
   // Zone offset register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // [4:0] zone_offset_hours, signed
);

   // Zone offset register.
   logic signed [4:0] zone_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= tld_pkg::ZONE_RESET;
      end else if (csr_valid) begin
         zone_ff <= $signed(csr_data);
      end
   end

   // Pipeline control: a stage loads when it is empty or when the stage after it moves on.
   logic [7:1] vld_ff;
   logic [7:1] vld_in;
   logic [7:1] en;

   assign en[7] = !vld_ff[7] || rsp_tready;
   assign en[6] = !vld_ff[6] || en[7];
   assign en[5] = !vld_ff[5] || en[6];
   assign en[4] = !vld_ff[4] || en[5];
   assign en[3] = !vld_ff[3] || en[4];
   assign en[2] = !vld_ff[2] || en[3];
   assign en[1] = !vld_ff[1] || en[2];

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[7];

   always_comb begin
      vld_in = {vld_ff[6:1], req_tvalid};
      for (int k = 1; k <= 7; k++) begin
         if (!en[k]) begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: clamp to the supported span and count seconds from 2000-01-01.
   logic [31:0] ts;
   logic [31:0] t1_in, t1_ff;

   always_comb begin
      ts = req_tdata;
      if (ts < tld_pkg::EPOCH_2000) begin
         ts = tld_pkg::EPOCH_2000;
      end else if (ts > tld_pkg::LAST_SECOND) begin
         ts = tld_pkg::LAST_SECOND;
      end
      t1_in = ts - tld_pkg::EPOCH_2000;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t1_ff <= t1_in;
      end
   end

   // Stage 2: day number. 86400 is 128 * 675, so the low seven bits are dropped first.
   logic [50:0] day_prod;
   logic [15:0] daynum2_in, daynum2_ff;
   logic [16:0] tlo2_ff;

   assign day_prod   = {26'd0, t1_ff[31:7]} * {25'd0, tld_pkg::RECIP_DAY};
   assign daynum2_in = day_prod[tld_pkg::DAY_SHIFT +: 16];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         daynum2_ff <= daynum2_in;
         tlo2_ff    <= t1_ff[16:0];
      end
   end

   // Stage 3: second of the day and four-year cycle index.
   logic [32:0] day_secs;
   logic [32:0] cycle_prod;
   logic [16:0] daysec3_in, daysec3_ff;
   logic [4:0]  cyc3_in, cyc3_ff;
   logic [15:0] daynum3_ff;

   assign day_secs   = {17'd0, daynum2_ff} * {16'd0, tld_pkg::SECS_PER_DAY};
   assign daysec3_in = tlo2_ff - day_secs[16:0];
   assign cycle_prod = {17'd0, daynum2_ff} * {16'd0, tld_pkg::RECIP_CYCLE};
   assign cyc3_in    = cycle_prod[tld_pkg::CYCLE_SHIFT +: 5];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         daysec3_ff <= daysec3_in;
         cyc3_ff    <= cyc3_in;
         daynum3_ff <= daynum2_ff;
      end
   end

   // Stage 4: day within the cycle and hour of the day.
   logic [15:0] cycle_days;
   logic [15:0] rem_full;
   logic [34:0] hour_prod;
   logic [10:0] rem4_in, rem4_ff;
   logic [4:0]  hour4_in, hour4_ff;
   logic [4:0]  cyc4_ff;
   logic [16:0] daysec4_ff;

   assign cycle_days = {11'd0, cyc3_ff} * {5'd0, tld_pkg::DAYS_PER_CYCLE};
   assign rem_full   = daynum3_ff - cycle_days;
   assign rem4_in    = rem_full[10:0];
   assign hour_prod  = {18'd0, daysec3_ff} * {17'd0, tld_pkg::RECIP_HOUR};
   assign hour4_in   = hour_prod[tld_pkg::HOUR_SHIFT +: 5];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rem4_ff    <= rem4_in;
         hour4_ff   <= hour4_in;
         cyc4_ff    <= cyc3_ff;
         daysec4_ff <= daysec3_ff;
      end
   end

   // Stage 5: year within the cycle (the first one is the leap year) and second of the hour.
   logic [10:0] after_leap;
   logic [1:0]  yoff;
   logic [10:0] doy_full;
   logic [16:0] hour_secs;
   logic [16:0] minsec_full;
   logic [6:0]  year5_in, year5_ff;
   logic        leap5_in, leap5_ff;
   logic [8:0]  doy5_in, doy5_ff;
   logic [11:0] minsec5_in, minsec5_ff;
   logic [4:0]  hour5_ff;

   always_comb begin
      after_leap = rem4_ff - tld_pkg::LEAP_YEAR_DAYS;
      if (rem4_ff < tld_pkg::LEAP_YEAR_DAYS) begin
         yoff     = 2'd0;
         doy_full = rem4_ff;
      end else if (after_leap >= tld_pkg::TWO_YEAR_DAYS) begin
         yoff     = 2'd3;
         doy_full = after_leap - tld_pkg::TWO_YEAR_DAYS;
      end else if (after_leap >= tld_pkg::YEAR_DAYS) begin
         yoff     = 2'd2;
         doy_full = after_leap - tld_pkg::YEAR_DAYS;
      end else begin
         yoff     = 2'd1;
         doy_full = after_leap;
      end
   end

   assign year5_in    = {cyc4_ff, yoff};
   assign leap5_in    = (yoff == 2'd0);
   assign doy5_in     = doy_full[8:0];
   assign hour_secs   = {12'd0, hour4_ff} * {5'd0, tld_pkg::SECS_PER_HOUR};
   assign minsec_full = daysec4_ff - hour_secs;
   assign minsec5_in  = minsec_full[11:0];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         year5_ff   <= year5_in;
         leap5_ff   <= leap5_in;
         doy5_ff    <= doy5_in;
         minsec5_ff <= minsec5_in;
         hour5_ff   <= hour4_ff;
      end
   end

   // Stage 6: month and day from the day of the year, and the minute.
   logic [3:0]  month6_in, month6_ff;
   logic [8:0]  day_full;
   logic [4:0]  day6_in, day6_ff;
   logic [24:0] minute_prod;
   logic [5:0]  minute6_in, minute6_ff;
   logic [6:0]  year6_ff;
   logic        leap6_ff;
   logic [11:0] minsec6_ff;
   logic [4:0]  hour6_ff;

   always_comb begin
      month6_in = tld_pkg::JANUARY;
      for (int m = 2; m <= 12; m++) begin
         if (doy5_ff >= tld_pkg::month_start(4'(m), leap5_ff)) begin
            month6_in = 4'(m);
         end
      end
      day_full = doy5_ff - tld_pkg::month_start(month6_in, leap5_ff) + 9'd1;
   end

   assign day6_in     = day_full[4:0];
   assign minute_prod = {13'd0, minsec5_ff} * {12'd0, tld_pkg::RECIP_MINUTE};
   assign minute6_in  = minute_prod[tld_pkg::MINUTE_SHIFT +: 6];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         month6_ff  <= month6_in;
         day6_ff    <= day6_in;
         minute6_ff <= minute6_in;
         year6_ff   <= year5_ff;
         leap6_ff   <= leap5_ff;
         minsec6_ff <= minsec5_ff;
         hour6_ff   <= hour5_ff;
      end
   end

   // Stage 7: the second, and the zone shift into the output register.
   tld_pkg::utc_date_type   utc6;
   tld_pkg::local_date_type loc7_in, loc7_ff;
   logic [11:0]             minute_secs;
   logic [11:0]             second_full;
   logic [5:0]              second7_in, second7_ff;
   logic [5:0]              minute7_ff;

   assign utc6.year_idx = year6_ff;
   assign utc6.leap     = leap6_ff;
   assign utc6.month    = month6_ff;
   assign utc6.day      = day6_ff;
   assign utc6.hour     = hour6_ff;
   assign utc6.zone     = zone_ff;

   tld_zone_shift u_zone_shift (
      .utc (utc6),
      .loc (loc7_in)
   );

   assign minute_secs = {6'd0, minute6_ff} * {6'd0, tld_pkg::SECS_PER_MINUTE};
   assign second_full = minsec6_ff - minute_secs;
   assign second7_in  = second_full[5:0];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         loc7_ff    <= loc7_in;
         second7_ff <= second7_in;
         minute7_ff <= minute6_ff;
      end
   end

   assign rsp_tdata = {2'b00, second7_ff, minute7_ff, loc7_ff.hour, loc7_ff.day,
                       loc7_ff.month, loc7_ff.year};

   // An output that is empty never holds back the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the output register is empty");

   // Every delivered date has its year, month and day within range for the shifted span.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (loc7_ff.year >= 12'd1999 && loc7_ff.year <= 12'd2100 &&
                      loc7_ff.month >= 4'd1 && loc7_ff.month <= 4'd12 &&
                      loc7_ff.day >= 5'd1 && loc7_ff.day <= 5'd31))
      else $error("delivered date out of range");

   // The reciprocal divisions must leave proper remainders.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (loc7_ff.hour <= 5'd23 && minute7_ff <= 6'd59 && second7_ff <= 6'd59))
      else $error("delivered time of day out of range");

   // A beat that reaches the output stage came from the stage before it.
   a_stage_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[7]) |-> $past(vld_ff[6]))
      else $error("output beat appeared without a source beat");

endmodule

@@ rtl/tld_zone_shift.sv @@
// Time-zone shift of a UTC date and hour with day, month and year rollover.
`timescale 1ns / 1ps

module tld_zone_shift (
   input  tld_pkg::utc_date_type   utc,
   output tld_pkg::local_date_type loc
);

   logic signed [4:0] zone;
   logic signed [6:0] hour_sum;
   logic [11:0]       year;
   logic [3:0]        prev_month;

   always_comb begin
      if (utc.zone < tld_pkg::ZONE_MIN) begin
         zone = tld_pkg::ZONE_MIN;
      end else if (utc.zone > tld_pkg::ZONE_MAX) begin
         zone = tld_pkg::ZONE_MAX;
      end else begin
         zone = utc.zone;
      end
   end

   assign hour_sum   = $signed({2'b00, utc.hour}) + $signed({{2{zone[4]}}, zone});
   assign year       = tld_pkg::BASE_YEAR + {5'd0, utc.year_idx};
   assign prev_month = utc.month - 4'd1;

   always_comb begin
      loc.year  = year;
      loc.month = utc.month;
      loc.day   = utc.day;
      loc.hour  = hour_sum[4:0];
      if (hour_sum < 7'sd0) begin
         // Local time falls on the previous day.
         loc.hour = 5'(hour_sum + $signed(tld_pkg::HOURS_PER_DAY));
         if (utc.day == 5'd1) begin
            if (utc.month == tld_pkg::JANUARY) begin
               loc.year  = year - 12'd1;
               loc.month = tld_pkg::DECEMBER;
               loc.day   = 5'd31;
            end else begin
               loc.month = prev_month;
               loc.day   = tld_pkg::month_days(prev_month, utc.leap);
            end
         end else begin
            loc.day = utc.day - 5'd1;
         end
      end else if (hour_sum >= $signed(tld_pkg::HOURS_PER_DAY)) begin
         // Local time falls on the next day.
         loc.hour = 5'(hour_sum - $signed(tld_pkg::HOURS_PER_DAY));
         if (utc.day == tld_pkg::month_days(utc.month, utc.leap)) begin
            loc.day = 5'd1;
            if (utc.month == tld_pkg::DECEMBER) begin
               loc.month = tld_pkg::JANUARY;
               loc.year  = year + 12'd1;
            end else begin
               loc.month = utc.month + 4'd1;
            end
         end else begin
            loc.day = utc.day + 5'd1;
         end
      end
   end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the timestamp to local date conversion core.
`timescale 1ns / 1ps

// Timestamps stream into the core and dated beats come back out. Each accepted timestamp is
// converted to a local date by a calendar model kept inside a small scoreboard, using the zone
// offset currently programmed. Each returned beat is checked in order against the oldest
// prediction. The run has three directed phases, one under the reset zone and two at the zone
// extremes, and ten random phases. The zone register is rewritten only between phases, after
// the pipeline has drained. The sender and the receiver each idle at their own rate, and that
// rate changes from phase to phase.

module tb_top;

   localparam int unsigned    CLOCK_HALF      = 5;
   localparam int unsigned    RESET_CYCLES    = 11;
   localparam int unsigned    DRAIN_CYCLES    = 16;     // pipeline is seven deep
   localparam int unsigned    CYCLE_LIMIT     = 400000;
   localparam int unsigned    MAX_REPORTS     = 10;
   localparam int unsigned    RANDOM_PHASES   = 10;
   localparam int unsigned    PHASE_BEATS     = 175;
   localparam int unsigned    DIRECTED_COUNT  = 9;
   localparam int unsigned    SPAN_FIRST      = 32'd946684800;   // 2000-01-01 00:00:00
   localparam int unsigned    SPAN_LAST       = 32'd4102444799;  // 2099-12-31 23:59:59
   localparam int unsigned    DAY_SECONDS     = 86400;
   localparam int unsigned    HOUR_SECONDS    = 3600;
   localparam int unsigned    CYCLE_DAYS      = 1461;            // four years, one of them leap
   localparam int unsigned    LEAP_DAYS       = 366;
   localparam int unsigned    COMMON_DAYS     = 365;
   localparam int             DAY_HOURS       = 24;
   localparam int             ZONE_LIMIT      = 12;
   localparam logic [4:0]     ZONE_AT_RESET   = 5'd8;

   // Layout of one result beat, lowest field in the lowest bits.
   typedef struct packed {
      logic [1:0]  pad;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } local_date_type;

   class date_scoreboard;
      local_date_type pending[$];
      logic [4:0]     zone_raw;
      int unsigned    errors;

      function new();
         zone_raw = ZONE_AT_RESET;
         errors   = 0;
      endfunction

      function void set_zone(logic [4:0] zone);
         zone_raw = zone;
      endfunction

      function int unsigned month_length(int unsigned yr, int unsigned mon);
         int unsigned n;
         case (mon)
            2: begin
               n = (yr % 4 == 0) ? 29 : 28;
            end
            4, 6, 9, 11: begin
               n = 30;
            end
            default: begin
               n = 31;
            end
         endcase
         return n;
      endfunction

      // Calendar date of one timestamp in the programmed zone.
      function local_date_type local_date_of(logic [31:0] stamp);
         longint unsigned secs;
         int unsigned     day_sec;
         int unsigned     day_num;
         int unsigned     rem;
         int unsigned     yr;
         int unsigned     mon;
         int unsigned     dy;
         int              hr;
         int              zone;
         local_date_type  d;
         secs = stamp;
         if (secs < SPAN_FIRST) begin
            secs = SPAN_FIRST;
         end
         if (secs > SPAN_LAST) begin
            secs = SPAN_LAST;
         end
         day_sec = int'(secs % DAY_SECONDS);
         hr      = int'(day_sec / HOUR_SECONDS);
         day_num = int'((secs - SPAN_FIRST) / DAY_SECONDS);
         yr      = 2000 + (day_num / CYCLE_DAYS) * 4;
         rem     = day_num % CYCLE_DAYS;
         // The first year of every four-year cycle is the leap one.
         if (rem >= LEAP_DAYS) begin
            rem = rem - LEAP_DAYS;
            yr  = yr + 1 + rem / COMMON_DAYS;
            rem = rem % COMMON_DAYS;
         end
         mon = 1;
         while (rem >= month_length(yr, mon)) begin
            rem = rem - month_length(yr, mon);
            mon = mon + 1;
         end
         dy = rem + 1;

         zone = int'($signed(zone_raw));
         if (zone > ZONE_LIMIT) begin
            zone = ZONE_LIMIT;
         end
         if (zone < -ZONE_LIMIT) begin
            zone = -ZONE_LIMIT;
         end
         hr = hr + zone;
         if (hr < 0) begin
            hr = hr + DAY_HOURS;
            dy = dy - 1;
            if (dy < 1) begin
               if (mon == 1) begin
                  yr  = yr - 1;
                  mon = 12;
                  dy  = 31;
               end else begin
                  mon = mon - 1;
                  dy  = month_length(yr, mon);
               end
            end
         end else if (hr >= DAY_HOURS) begin
            hr = hr - DAY_HOURS;
            dy = dy + 1;
            if (dy > month_length(yr, mon)) begin
               dy  = 1;
               mon = mon + 1;
               if (mon > 12) begin
                  mon = 1;
                  yr  = yr + 1;
               end
            end
         end

         d        = '0;
         d.year   = yr[11:0];
         d.month  = mon[3:0];
         d.day    = dy[4:0];
         d.hour   = hr[4:0];
         d.minute = 6'((day_sec % HOUR_SECONDS) / 60);
         d.second = 6'(day_sec % 60);
         return d;
      endfunction

      function void note_timestamp(logic [31:0] stamp);
         pending.push_back(local_date_of(stamp));
      endfunction

      function void check_date(local_date_type got);
         local_date_type want;
         if (pending.size() == 0) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected date beat %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                        got.day, got.hour, got.minute, got.second);
            end
            return;
         end
         want = pending.pop_front();
         if (got.year != want.year || got.month != want.month || got.day != want.day ||
             got.hour != want.hour || got.minute != want.minute ||
             got.second != want.second) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS) begin
               $display("date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, ",
                        want.year, want.month, want.day, want.hour, want.minute, want.second,
                        "got %0d-%0d-%0d %0d:%0d:%0d",
                        got.year, got.month, got.day, got.hour, got.minute, got.second);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data   = '0;

   date_scoreboard sb;
   int unsigned    send_idle_pct  = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    cycle_count    = 0;

   // Boundary timestamps: before, at and after the span, leap and common February ends.
   logic [31:0] boundary_stamps [DIRECTED_COUNT] = '{
      32'd0,            // far before the span
      32'd946684799,    // one second before the span
      32'd946684800,    // first second of 2000
      32'd951868799,    // 2000-02-29 23:59:59
      32'd983404799,    // 2001-02-28 23:59:59
      32'd1078099199,   // 2004-02-29 23:59:59
      32'd4102444799,   // last second of 2099
      32'd4102444800,   // one second past the span
      32'hFFFFFFFF      // largest timestamp
   };

   timestamp_to_local_date_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever begin
         #CLOCK_HALF clock = ~clock;
      end
   end

   // The receiver decides afresh every cycle whether it takes a beat.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Both handshakes are observed on the values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_timestamp(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_date(local_date_type'(rsp_tdata));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // One timestamp beat, after a random number of idle cycles. The valid stays high when
   // no gap follows, so back-to-back beats never see it dropped.
   task automatic send_timestamp(input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // The first edge lets the monitor record a beat accepted at the current edge before the
   // queue of predictions is looked at.
   task automatic drain_pipeline();
      @(posedge clock);
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The zone changes only on an empty pipeline, so no beat in flight sees a mixed setting.
   task automatic write_zone(input logic [4:0] zone);
      req_tvalid <= 1'b0;
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= zone;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      sb.set_zone(zone);
   endtask

   task automatic set_idling(input int unsigned scheme);
      case (scheme % 4)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 68;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 68;
         end
         default: begin
            send_idle_pct  = 30;
            recv_stall_pct = 30;
         end
      endcase
   endtask

   // Mostly timestamps inside the span, a share placed within thirteen hours of a month start
   // so that the zone shift crosses a month or year boundary, and some from the whole range.
   function automatic logic [31:0] random_timestamp();
      int unsigned     pick;
      int unsigned     year_idx;
      int unsigned     mon;
      int unsigned     m;
      longint unsigned days;
      longint unsigned stamp;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return $urandom();
      end
      if (pick < 30) begin
         year_idx = $urandom_range(99);
         mon      = $urandom_range(12, 1);
         days     = year_idx * 365 + (year_idx + 3) / 4;
         for (m = 1; m < mon; m++) begin
            days = days + sb.month_length(2000 + year_idx, m);
         end
         stamp = SPAN_FIRST + days * DAY_SECONDS;
         if ($urandom_range(1) == 1) begin
            stamp = stamp + $urandom_range(13 * HOUR_SECONDS);
         end else begin
            stamp = stamp - $urandom_range(13 * HOUR_SECONDS);
         end
         return stamp[31:0];
      end
      return SPAN_FIRST + $urandom_range(SPAN_LAST - SPAN_FIRST);
   endfunction

   initial begin
      int unsigned i;
      int unsigned p;
      logic [4:0]  zone;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Boundary timestamps under the reset zone and then both ends of the zone range, which
      // rolls the first day of 2000 back into 1999 and the last day of 2099 into 2100.
      for (p = 0; p < 3; p++) begin
         if (p == 1) begin
            write_zone(-5'sd12);
         end else if (p == 2) begin
            write_zone(5'sd12);
         end
         set_idling(p);
         for (i = 0; i < DIRECTED_COUNT; i++) begin
            send_timestamp(boundary_stamps[i]);
         end
      end

      // Random phases walk through zones inside the range and raw codes beyond it.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: zone = 5'd0;
            1: zone = 5'b10100;   // -12
            2: zone = 5'd12;
            3: zone = 5'd13;
            4: zone = 5'd15;
            5: zone = 5'b10011;   // -13
            6: zone = 5'b10000;   // -16
            7: zone = 5'd5;
            8: zone = 5'b11011;   // -5
            default: zone = ZONE_AT_RESET;
         endcase
         write_zone(zone);
         set_idling(p + 1);
         for (i = 0; i < PHASE_BEATS; i++) begin
            send_timestamp(random_timestamp());
         end
      end
      req_tvalid <= 1'b0;
      drain_pipeline();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tld_pkg.sv
rtl/tld_zone_shift.sv
rtl/timestamp_to_local_date_core.sv
dv/tb_top.sv
